/* hw/rtl/mfs_pkg.sv */
package mfs_pkg;

  localparam int unsigned EntryCapacityDefault  = 256;
  localparam int unsigned DistinctValuesDefault = 64;
  localparam int unsigned ValueWidthDefault     = 32;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_PUSHED    = 2'd0,
    ST_POPPED    = 2'd1,
    ST_POP_EMPTY = 2'd2,
    ST_PUSH_FULL = 2'd3
  } status_t;

  // Request codes.
  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_PUSH,
    S_PFETCH,
    S_PREAD,
    S_PPOP,
    S_DONE
  } state_t;

endpackage

/* hw/rtl/mfs_ram.sv */
module mfs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/max_frequency_stack.sv */
// Channel    Signals                                   Direction
// request    in_valid, in_ready, req_type, push_value  into the block
// result     out_valid, out_ready, popped_value, status out of the block
//
// One request is handled at a time. A push walks the count table one slot per cycle through
// its single read port, then uses the level-head and entry memories; a pop uses those memories
// first and then walks the count table to lower the popped value's count. A pop that finds the
// stack empty goes straight to its result. The result waits in an output register,
// so a stalled result channel holds the block only once the next request is ready to deliver.
// High-water marks tell written entries from fresh ones, so reset does no clearing.
module max_frequency_stack #(
  parameter int unsigned ENTRY_CAPACITY  = mfs_pkg::EntryCapacityDefault,
  parameter int unsigned DISTINCT_VALUES = mfs_pkg::DistinctValuesDefault,
  parameter int unsigned VALUE_WIDTH     = mfs_pkg::ValueWidthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [31:0] push_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] popped_value,
  output logic [1:0]  status
);

  localparam int unsigned EW = $clog2(ENTRY_CAPACITY);
  localparam int unsigned PW = EW + 1;                      // entry pointer with "none"
  localparam int unsigned SW = $clog2(DISTINCT_VALUES);
  localparam int unsigned CW = $clog2(ENTRY_CAPACITY + 1);  // count / level
  localparam int unsigned VW = VALUE_WIDTH;
  localparam logic [PW-1:0] NONE = PW'(ENTRY_CAPACITY);
  localparam logic [SW-1:0] LAST_SLOT = SW'(DISTINCT_VALUES - 1);
  localparam logic [EW-1:0] LAST_ENTRY = EW'(ENTRY_CAPACITY - 1);

  mfs_pkg::state_t state, state_next;

  // Request context.
  logic                 is_pop;
  logic [VW-1:0]        val;
  logic [SW:0]          scan_idx;
  logic                 chk;
  logic [SW-1:0]        chk_idx;
  logic                 found;
  logic [SW-1:0]        slot;
  logic                 have_free;
  logic [SW-1:0]        free_slot;
  logic [CW-1:0]        cnt;
  logic [EW-1:0]        e_idx;
  mfs_pkg::status_t     res_status;
  logic [VW-1:0]        res_value;

  // Structure state held in flops.
  logic [PW-1:0]        free_head;
  logic [PW-1:0]        fresh;      // entries below this one have been written
  logic [CW-1:0]        top;
  logic [CW-1:0]        hwm;        // level heads up to this level have been written
  logic [DISTINCT_VALUES-1:0] key_valid;

  // Memory ports.
  logic                 ent_we,  lvl_we,  key_we;
  logic [EW-1:0]        ent_waddr, ent_raddr, lvl_waddr, lvl_raddr;
  logic [SW-1:0]        key_waddr, key_raddr;
  logic [VW+EW-1:0]     ent_wdata, ent_rdata;
  logic [PW-1:0]        lvl_wdata, lvl_rdata;
  logic [CW+VW-1:0]     key_wdata, key_rdata;

  mfs_ram #(.WIDTH(VW + EW), .DEPTH(ENTRY_CAPACITY)) u_entry_ram (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .raddr(ent_raddr), .rdata(ent_rdata)
  );

  mfs_ram #(.WIDTH(PW), .DEPTH(ENTRY_CAPACITY)) u_level_ram (
    .clk(clk), .we(lvl_we), .waddr(lvl_waddr), .wdata(lvl_wdata),
    .raddr(lvl_raddr), .rdata(lvl_rdata)
  );

  mfs_ram #(.WIDTH(CW + VW), .DEPTH(DISTINCT_VALUES)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
    .raddr(key_raddr), .rdata(key_rdata)
  );

  // Helper signals.
  logic [63:0]   push_ext;
  logic [63:0]   pop_ext;
  logic          accept;
  logic          hit;
  logic          scan_end;
  logic [VW-1:0] key_val;
  logic [CW-1:0] key_cnt;
  logic [CW-1:0] key_cnt_dec;
  logic [CW-1:0] push_lvl;
  logic          push_full;
  logic [EW-1:0] lidx;
  logic          head_none;
  logic [EW-1:0] link_eff;
  logic [SW-1:0] slot_sel;
  logic [EW-1:0] top_idx;
  logic [VW-1:0] ent_val;
  logic [EW-1:0] ent_link;
  logic          lvl_empties;
  logic          out_free;

  assign push_ext    = 64'(push_value);
  assign pop_ext     = 64'(res_value);
  assign in_ready    = (state == mfs_pkg::S_IDLE);
  assign accept      = in_valid && in_ready;
  assign out_free    = !out_valid || out_ready;

  assign key_val     = key_rdata[VW-1:0];
  assign key_cnt     = key_rdata[CW+VW-1:VW];
  assign key_cnt_dec = (key_cnt == '0) ? '0 : key_cnt - CW'(1);
  assign hit         = chk && key_valid[chk_idx] && (key_val == val);
  assign scan_end    = hit || (chk && chk_idx == LAST_SLOT);

  assign push_lvl    = found ? cnt + CW'(1) : CW'(1);
  assign push_full   = (!found && !have_free) || (free_head == NONE);
  assign lidx        = EW'(cnt - CW'(1));
  assign head_none   = (cnt > hwm) || (lvl_rdata == NONE);
  assign slot_sel    = found ? slot : free_slot;
  assign top_idx     = EW'(top - CW'(1));

  assign ent_val     = ent_rdata[VW+EW-1:EW];
  // An entry never written still carries its place in the initial free chain.
  always_comb begin
    if (PW'(e_idx) < fresh) begin
      link_eff = ent_rdata[EW-1:0];
    end else if (e_idx == LAST_ENTRY) begin
      link_eff = e_idx;
    end else begin
      link_eff = e_idx + EW'(1);
    end
  end
  assign ent_link    = ent_rdata[EW-1:0];
  assign lvl_empties = (ent_link == e_idx);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      mfs_pkg::S_IDLE: begin
        if (accept) begin
          if (req_type == mfs_pkg::REQ_PUSH) begin
            state_next = mfs_pkg::S_SCAN;
          end else if (top == '0) begin
            state_next = mfs_pkg::S_DONE;
          end else begin
            state_next = mfs_pkg::S_PFETCH;
          end
        end
      end
      mfs_pkg::S_SCAN: begin
        if (scan_end) begin
          state_next = is_pop ? mfs_pkg::S_DONE : mfs_pkg::S_FETCH;
        end
      end
      mfs_pkg::S_FETCH:  state_next = push_full ? mfs_pkg::S_DONE : mfs_pkg::S_PUSH;
      mfs_pkg::S_PUSH:   state_next = mfs_pkg::S_DONE;
      mfs_pkg::S_PFETCH: state_next = mfs_pkg::S_PREAD;
      mfs_pkg::S_PREAD:  state_next = mfs_pkg::S_PPOP;
      mfs_pkg::S_PPOP:   state_next = mfs_pkg::S_SCAN;
      mfs_pkg::S_DONE: begin
        if (out_free) begin
          state_next = mfs_pkg::S_IDLE;
        end
      end
      default: state_next = mfs_pkg::S_IDLE;
    endcase
  end

  // Memory controls.
  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = e_idx;
    ent_wdata = {val, e_idx};
    ent_raddr = e_idx;
    lvl_we    = 1'b0;
    lvl_waddr = lidx;
    lvl_wdata = {1'b0, e_idx};
    lvl_raddr = lidx;
    key_we    = 1'b0;
    key_waddr = chk_idx;
    key_wdata = {key_cnt_dec, val};
    key_raddr = scan_idx[SW-1:0];
    case (state)
      mfs_pkg::S_SCAN: begin
        // A pop lowers the count of the value it removed.
        key_we = is_pop && hit;
      end
      mfs_pkg::S_FETCH: begin
        ent_raddr = free_head[EW-1:0];
        lvl_raddr = EW'(push_lvl - CW'(1));
      end
      mfs_pkg::S_PUSH: begin
        ent_we    = 1'b1;
        ent_wdata = {val, head_none ? e_idx : lvl_rdata[EW-1:0]};
        lvl_we    = 1'b1;
        key_we    = 1'b1;
        key_waddr = slot_sel;
        key_wdata = {cnt, val};
      end
      mfs_pkg::S_PFETCH: begin
        lvl_raddr = top_idx;
      end
      mfs_pkg::S_PREAD: begin
        ent_raddr = lvl_rdata[EW-1:0];
      end
      mfs_pkg::S_PPOP: begin
        ent_we    = 1'b1;
        ent_wdata = {ent_val, (free_head == NONE) ? e_idx : free_head[EW-1:0]};
        lvl_we    = 1'b1;
        lvl_waddr = top_idx;
        lvl_wdata = lvl_empties ? NONE : {1'b0, ent_link};
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mfs_pkg::S_IDLE;
      free_head <= '0;
      fresh     <= '0;
      top       <= '0;
      hwm       <= '0;
      key_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready && state != mfs_pkg::S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        mfs_pkg::S_SCAN: begin
          if (is_pop && hit && key_cnt_dec == '0) begin
            key_valid[chk_idx] <= 1'b0;
          end
        end
        mfs_pkg::S_PUSH: begin
          key_valid[slot_sel] <= 1'b1;
          free_head <= (link_eff == e_idx) ? NONE : {1'b0, link_eff};
          if (PW'(e_idx) >= fresh) begin
            fresh <= fresh + PW'(1);
          end
          if (cnt > top) begin
            top <= cnt;
          end
          if (cnt > hwm) begin
            hwm <= cnt;
          end
        end
        mfs_pkg::S_PPOP: begin
          free_head <= {1'b0, e_idx};
          if (lvl_empties) begin
            top <= top - CW'(1);
          end
        end
        mfs_pkg::S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Request context and result payload.
  always_ff @(posedge clk) begin
    case (state)
      mfs_pkg::S_IDLE: begin
        is_pop     <= (req_type == mfs_pkg::REQ_POP);
        val        <= push_ext[VW-1:0];
        res_value  <= '0;
        res_status <= (req_type == mfs_pkg::REQ_POP) ? mfs_pkg::ST_POP_EMPTY
                                                     : mfs_pkg::ST_PUSHED;
        scan_idx   <= '0;
        chk        <= 1'b0;
        found      <= 1'b0;
        have_free  <= 1'b0;
      end
      mfs_pkg::S_SCAN: begin
        chk      <= (scan_idx < (SW + 1)'(DISTINCT_VALUES));
        chk_idx  <= scan_idx[SW-1:0];
        scan_idx <= scan_idx + (SW + 1)'(1);
        if (hit) begin
          found <= 1'b1;
          slot  <= chk_idx;
          cnt   <= key_cnt;
        end else if (chk && !key_valid[chk_idx] && !have_free) begin
          have_free <= 1'b1;
          free_slot <= chk_idx;
        end
      end
      mfs_pkg::S_FETCH: begin
        cnt   <= push_lvl;
        e_idx <= free_head[EW-1:0];
        if (push_full) begin
          res_status <= mfs_pkg::ST_PUSH_FULL;
        end
      end
      mfs_pkg::S_PREAD: begin
        e_idx <= lvl_rdata[EW-1:0];
      end
      mfs_pkg::S_PPOP: begin
        val        <= ent_val;
        res_value  <= ent_val;
        res_status <= mfs_pkg::ST_POPPED;
        scan_idx   <= '0;
        chk        <= 1'b0;
        found      <= 1'b0;
        have_free  <= 1'b0;
      end
      mfs_pkg::S_DONE: begin
        if (out_free) begin
          popped_value <= pop_ext[31:0];
          status       <= res_status;
        end
      end
      default: ;
    endcase
  end

endmodule

/* sim/max_frequency_stack_checker.sv */
`timescale 1ns / 1ps

module max_frequency_stack_checker #(
  parameter int unsigned ENTRY_CAPACITY  = mfs_pkg::EntryCapacityDefault,
  parameter int unsigned DISTINCT_VALUES = mfs_pkg::DistinctValuesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        req_type,
  input  logic [31:0] push_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] popped_value,
  input  logic [1:0]  status,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic [31:0]      value;
    mfs_pkg::status_t st;
  } outcome_t;

  // Shadow copy of the frequency stack.
  logic [31:0] ent_val [ENTRY_CAPACITY];
  int          ent_next[ENTRY_CAPACITY];
  int          lvl_head[ENTRY_CAPACITY];
  int          free_ptr;
  logic [31:0] key_val [DISTINCT_VALUES];
  int          key_cnt [DISTINCT_VALUES];
  logic        key_used[DISTINCT_VALUES];
  int          top_lvl;

  outcome_t    expected_q[$];

  function automatic int slot_of(logic [31:0] v);
    for (int i = 0; i < DISTINCT_VALUES; i++)
      if (key_used[i] && key_val[i] == v) return i;
    return DISTINCT_VALUES;
  endfunction

  function automatic outcome_t apply_request(mfs_pkg::req_t rt, logic [31:0] v);
    outcome_t r;
    int slot, lvl, e, nx, idx;
    r.value = '0;
    r.st    = mfs_pkg::ST_PUSH_FULL;
    if (rt == mfs_pkg::REQ_PUSH) begin
      slot = slot_of(v);
      if (slot == DISTINCT_VALUES) begin
        for (int i = DISTINCT_VALUES - 1; i >= 0; i--)
          if (!key_used[i]) slot = i;
        if (slot == DISTINCT_VALUES) return r;
      end
      if (free_ptr >= ENTRY_CAPACITY) return r;
      lvl = (key_used[slot] ? key_cnt[slot] : 0) + 1;
      if (lvl > ENTRY_CAPACITY) return r;
      e  = free_ptr;
      nx = ent_next[e];
      free_ptr = (nx == e) ? ENTRY_CAPACITY : nx;
      key_used[slot] = 1'b1;
      key_val[slot]  = v;
      key_cnt[slot]  = lvl;
      ent_val[e]  = v;
      ent_next[e] = (lvl_head[lvl-1] >= ENTRY_CAPACITY) ? e : lvl_head[lvl-1];
      lvl_head[lvl-1] = e;
      if (lvl > top_lvl) top_lvl = lvl;
      r.st = mfs_pkg::ST_PUSHED;
    end else begin
      r.st = mfs_pkg::ST_POP_EMPTY;
      if (top_lvl == 0) return r;
      idx = top_lvl - 1;
      e   = lvl_head[idx];
      nx  = ent_next[e];
      lvl_head[idx] = (nx == e) ? ENTRY_CAPACITY : nx;
      ent_next[e] = (free_ptr >= ENTRY_CAPACITY) ? e : free_ptr;
      free_ptr = e;
      if (lvl_head[idx] >= ENTRY_CAPACITY) top_lvl--;
      slot = slot_of(ent_val[e]);
      if (slot < DISTINCT_VALUES) begin
        if (key_cnt[slot] > 0) key_cnt[slot]--;
        if (key_cnt[slot] == 0) key_used[slot] = 1'b0;
      end
      r.value = ent_val[e];
      r.st    = mfs_pkg::ST_POPPED;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      for (int i = 0; i < ENTRY_CAPACITY; i++) begin
        ent_val[i]  = '0;
        ent_next[i] = (i + 1 < ENTRY_CAPACITY) ? i + 1 : i;
        lvl_head[i] = ENTRY_CAPACITY;
      end
      for (int i = 0; i < DISTINCT_VALUES; i++) begin
        key_val[i]  = '0;
        key_cnt[i]  = 0;
        key_used[i] = 1'b0;
      end
      free_ptr = 0;
      top_lvl  = 0;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      // A result always belongs to an earlier request, so compare first.
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result value=%h status=%0d", $time,
                   popped_value, status);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (popped_value !== want.value || status !== want.st) begin
            $display("%0t: mismatch expected value=%h status=%0d, got value=%h status=%0d",
                     $time, want.value, want.st, popped_value, status);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready)
        expected_q.insert(expected_q.size(),
                          apply_request(mfs_pkg::req_t'(req_type), push_value));
    end
    pending = expected_q.size();
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  // The limit covers the slowest request, a table walk, plus the longest
  // idle and stall bursts, several times over.
  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        req_type;
  logic [31:0] push_value;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] popped_value;
  logic [1:0]  status;
  int          fail_count;
  int          pending;
  int          idle_cycles;
  bit          quiet;

  max_frequency_stack u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .push_value(push_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .popped_value(popped_value), .status(status)
  );

  max_frequency_stack_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .push_value(push_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .popped_value(popped_value), .status(status),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: counts cycles in which neither channel moves a request or result.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // The result side stalls in random bursts, except in the quiet tail.
  initial begin
    int run;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (quiet) begin
        out_ready = 1'b1;
        @(negedge clk);
      end else begin
        run = $urandom_range(1, 20);
        out_ready = 1'b1;
        repeat (run) @(negedge clk);
        if (!quiet && $urandom_range(0, 2) == 0) begin
          run = $urandom_range(1, 14);
          out_ready = 1'b0;
          repeat (run) @(negedge clk);
        end
      end
    end
  end

  // Presents one request at a falling edge and holds it until accepted.
  // A random idle burst may come first; the task returns at a falling edge.
  task automatic send_request(mfs_pkg::req_t rt, logic [31:0] v);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    req_type   = rt;
    push_value = v;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  // Stall the request side until every outstanding result has come back.
  task automatic drain_results();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Random phase: values mostly from a small pool so counts climb high;
  // push_bias out of 100 sets how hard the phase leans toward pushes.
  task automatic random_phase(int n, int push_bias, int pool);
    logic [31:0] v;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) v = $urandom();
      else v = 32'h5A00_0000 + $urandom_range(0, pool - 1);
      if ($urandom_range(1, 100) <= push_bias) send_request(mfs_pkg::REQ_PUSH, v);
      else send_request(mfs_pkg::REQ_POP, '0);
    end
  endtask

  initial begin
    in_valid   = 1'b0;
    req_type   = mfs_pkg::REQ_PUSH;
    push_value = '0;
    quiet      = 1'b0;
    rst        = 1'b1;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Directed part: the empty pop, the value extremes, tie breaking
    // between equal counts, and draining back to the empty state.
    send_request(mfs_pkg::REQ_POP, 32'hFFFF_FFFF);
    send_request(mfs_pkg::REQ_PUSH, 32'h0000_0000);
    send_request(mfs_pkg::REQ_PUSH, 32'hFFFF_FFFF);
    send_request(mfs_pkg::REQ_PUSH, 32'h0000_0000);
    send_request(mfs_pkg::REQ_PUSH, 32'hA5A5_5A5A);
    send_request(mfs_pkg::REQ_PUSH, 32'hFFFF_FFFF);
    send_request(mfs_pkg::REQ_PUSH, 32'h0000_0000);
    for (int i = 0; i < 7; i++) send_request(mfs_pkg::REQ_POP, 32'h1234_5678);

    // Pause the request side completely until all results are in.
    drain_results();

    // Distinct-value table full: 64 different values fit, the 65th is refused,
    // and a repeat of an existing value still goes in.
    for (int i = 0; i <= 64; i++) send_request(mfs_pkg::REQ_PUSH, 32'h0100_0000 + i);
    send_request(mfs_pkg::REQ_PUSH, 32'h0100_0003);
    random_phase(20, 30, 64);
    for (int i = 0; i < 70; i++) send_request(mfs_pkg::REQ_POP, '0);

    // Entry pool full: more pushes of few values than there are entries.
    random_phase(320, 92, 6);
    random_phase(300, 8, 6);

    // Mixed traffic, then the quiet tail with no idling on either side.
    random_phase(100, 55, 12);
    random_phase(60, 60, 90);
    quiet = 1'b1;
    random_phase(80, 50, 10);

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/mfs_pkg.sv
hw/rtl/mfs_ram.sv
hw/rtl/max_frequency_stack.sv
sim/max_frequency_stack_checker.sv
sim/testbench.sv
